[design/thie_pkg.sv]
`timescale 1ns / 1ps

package thie_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [4:0] {
      CMD_BX         = 5'd0,
      CMD_BLX        = 5'd1,
      CMD_CBZ        = 5'd2,
      CMD_CBNZ       = 5'd3,
      CMD_PUSH       = 5'd4,
      CMD_POP        = 5'd5,
      CMD_LDR_LIT    = 5'd6,
      CMD_LDR        = 5'd7,
      CMD_STR        = 5'd8,
      CMD_MOV        = 5'd9,
      CMD_MOVIMM     = 5'd10,
      CMD_ADDIMM     = 5'd11,
      CMD_ADDRRR     = 5'd12,
      CMD_ADDRRI     = 5'd13,
      CMD_SUBRRR     = 5'd14,
      CMD_SUBRRI     = 5'd15,
      CMD_NOP        = 5'd16,
      CMD_BKPT       = 5'd17,
      CMD_BREAKPOINT = 5'd18
   } command_type;

   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_LR = 4'd14;
   localparam logic [3:0] REG_PC = 4'd15;

   // Opcode templates for the instruction forms.
   localparam logic [15:0] OP_BX        = 16'h4700;
   localparam logic [15:0] OP_BLX       = 16'h4780;
   localparam logic [15:0] OP_CBZ       = 16'hb100;
   localparam logic [15:0] OP_CBNZ      = 16'hb900;
   localparam logic [15:0] OP_PUSH      = 16'hb400;
   localparam logic [15:0] OP_POP       = 16'hbc00;
   localparam logic [15:0] OP_LDR_LIT   = 16'h4800;
   localparam logic [15:0] OP_MEM_SP    = 16'h9000;
   localparam logic [15:0] OP_MEM_IMM   = 16'h6000;
   localparam logic [15:0] OP_MEM_LOAD  = 16'h0800;
   localparam logic [15:0] OP_MOV_HI    = 16'h4600;
   localparam logic [15:0] OP_MOV_LO    = 16'h1c00;
   localparam logic [15:0] OP_MOVIMM    = 16'h2000;
   localparam logic [15:0] OP_ADD_SPIMM = 16'hb000;
   localparam logic [15:0] OP_ADD_IMM8  = 16'h3000;
   localparam logic [15:0] OP_ADD_HI    = 16'h4400;
   localparam logic [15:0] OP_ADD_RRR   = 16'h1800;
   localparam logic [15:0] OP_SUB_RRR   = 16'h1a00;
   localparam logic [15:0] OP_ADR       = 16'ha000;
   localparam logic [15:0] OP_ADD_IMM3  = 16'h1c00;
   localparam logic [15:0] OP_NOP       = 16'h46c0;
   localparam logic [15:0] OP_BKPT      = 16'hbe00;
   localparam logic [15:0] OP_BX_LR     = OP_BX | {9'd0, REG_LR, 3'd0};

   // One request transaction as held in the input register.
   typedef struct packed {
      command_type       command;
      logic [3:0]        dst_reg;
      logic [3:0]        src_a_reg;
      logic [3:0]        src_b_reg;
      logic signed [10:0] immediate;
      logic [8:0]        reg_list;
      logic [7:0]        fixup_distance;
   } req_item_type;

   // First (or only) halfword produced for a command.
   typedef struct packed {
      logic [15:0] halfword;
      logic        last;
      logic        error;
   } enc_result_type;

endpackage

[design/thie_encoder.sv]
`timescale 1ns / 1ps

module thie_encoder (
   input  thie_pkg::req_item_type   item,
   output thie_pkg::enc_result_type result
);

   // Add immediate to a register (or to sp).
   function automatic thie_pkg::enc_result_type enc_addimm(
      input logic [3:0]  d,
      input logic        neg,
      input logic [10:0] mag
   );
      thie_pkg::enc_result_type r;
      r.last = 1'b1;
      if (d == thie_pkg::REG_SP) begin
         r.error    = (mag[1:0] != 2'd0) || (mag > 11'd508);
         r.halfword = thie_pkg::OP_ADD_SPIMM | {8'd0, neg, mag[8:2]};
      end else begin
         r.error    = (mag > 11'd255) || d[3];
         r.halfword = thie_pkg::OP_ADD_IMM8 | {4'd0, neg, d[2:0], mag[7:0]};
      end
      return r;
   endfunction

   // Three-operand add of an immediate; falls back to the two-operand form.
   function automatic thie_pkg::enc_result_type enc_addrri(
      input logic [3:0]  d,
      input logic [3:0]  l,
      input logic        neg,
      input logic [10:0] mag
   );
      thie_pkg::enc_result_type r;
      r.last = 1'b1;
      if (l == d) begin
         r = enc_addimm(d, neg, mag);
      end else if (l == thie_pkg::REG_SP || l == thie_pkg::REG_PC) begin
         r.error    = neg || (mag[1:0] != 2'd0) || (mag > 11'd1020) || d[3];
         r.halfword = thie_pkg::OP_ADR
                    | {4'd0, (l == thie_pkg::REG_SP), d[2:0], mag[9:2]};
      end else begin
         r.error    = (mag > 11'd7) || l[3] || d[3];
         r.halfword = thie_pkg::OP_ADD_IMM3
                    | {6'd0, neg, mag[2:0], l[2:0], d[2:0]};
      end
      return r;
   endfunction

   logic [10:0] imm_bits;
   logic        imm_neg;
   logic [10:0] imm_mag;
   logic        imm_over_byte;
   logic        mem_misaligned;
   logic        mem_base_sp;
   logic        mem_too_far;
   logic [15:0] mem_halfword;
   logic        mem_error;
   logic        sub_neg;

   assign imm_bits      = item.immediate;
   assign imm_neg       = imm_bits[10];
   assign imm_mag       = imm_neg ? (~imm_bits + 11'd1) : imm_bits;
   assign imm_over_byte = imm_neg || (imm_bits[9:8] != 2'd0);
   // Subtract forms add the negated immediate, so its sign flips.
   assign sub_neg       = !imm_neg && (imm_bits != 11'd0);

   // Load/store with an immediate byte offset, sp-relative or register base.
   assign mem_misaligned = imm_neg || (imm_bits[1:0] != 2'd0);
   assign mem_base_sp    = (item.src_a_reg == thie_pkg::REG_SP);
   assign mem_too_far    = mem_base_sp ? (imm_bits[9:0] > 10'd1020)
                                       : (imm_bits[9:0] > 10'd124);

   always_comb begin
      if (mem_base_sp) begin
         mem_halfword = thie_pkg::OP_MEM_SP
                      | {5'd0, item.dst_reg[2:0], imm_bits[9:2]};
         mem_error    = mem_misaligned || (!imm_neg && mem_too_far)
                      || item.dst_reg[3];
      end else begin
         mem_halfword = thie_pkg::OP_MEM_IMM
                      | {5'd0, imm_bits[6:2], item.src_a_reg[2:0], item.dst_reg[2:0]};
         mem_error    = mem_misaligned || (!imm_neg && mem_too_far)
                      || item.src_a_reg[3] || item.dst_reg[3];
      end
   end

   always_comb begin
      result.halfword = 16'd0;
      result.last     = 1'b1;
      result.error    = 1'b0;
      unique case (item.command)
         thie_pkg::CMD_BX: begin
            result.halfword = thie_pkg::OP_BX | {9'd0, item.dst_reg, 3'd0};
         end
         thie_pkg::CMD_BLX: begin
            result.halfword = thie_pkg::OP_BLX | {9'd0, item.dst_reg, 3'd0};
         end
         thie_pkg::CMD_CBZ, thie_pkg::CMD_CBNZ: begin
            result.error    = (item.fixup_distance[7:6] != 2'd0) || item.dst_reg[3];
            result.halfword = ((item.command == thie_pkg::CMD_CBZ) ? thie_pkg::OP_CBZ
                                                                   : thie_pkg::OP_CBNZ)
                            | {6'd0, item.fixup_distance[5], 1'b0,
                               item.fixup_distance[4:0], item.dst_reg[2:0]};
         end
         thie_pkg::CMD_PUSH, thie_pkg::CMD_POP: begin
            result.error    = (item.reg_list == 9'd0);
            result.halfword = ((item.command == thie_pkg::CMD_PUSH) ? thie_pkg::OP_PUSH
                                                                    : thie_pkg::OP_POP)
                            | {7'd0, item.reg_list};
         end
         thie_pkg::CMD_LDR_LIT: begin
            result.error    = item.dst_reg[3];
            result.halfword = thie_pkg::OP_LDR_LIT
                            | {5'd0, item.dst_reg[2:0], item.fixup_distance};
         end
         thie_pkg::CMD_LDR: begin
            result.error    = mem_error;
            result.halfword = mem_halfword | thie_pkg::OP_MEM_LOAD;
         end
         thie_pkg::CMD_STR: begin
            result.error    = mem_error;
            result.halfword = mem_halfword;
         end
         thie_pkg::CMD_MOV: begin
            if (!item.dst_reg[3] && !item.src_b_reg[3]) begin
               result.halfword = thie_pkg::OP_MOV_LO
                               | {10'd0, item.src_b_reg[2:0], item.dst_reg[2:0]};
            end else begin
               result.halfword = thie_pkg::OP_MOV_HI
                               | {8'd0, item.dst_reg[3], item.src_b_reg,
                                  item.dst_reg[2:0]};
            end
         end
         thie_pkg::CMD_MOVIMM: begin
            result.error    = imm_over_byte || item.dst_reg[3];
            result.halfword = thie_pkg::OP_MOVIMM
                            | {5'd0, item.dst_reg[2:0], imm_bits[7:0]};
         end
         thie_pkg::CMD_ADDIMM: begin
            result = enc_addimm(item.dst_reg, imm_neg, imm_mag);
         end
         thie_pkg::CMD_ADDRRR: begin
            if (item.src_a_reg == item.dst_reg) begin
               result.halfword = thie_pkg::OP_ADD_HI
                               | {8'd0, item.dst_reg[3], item.src_b_reg,
                                  item.dst_reg[2:0]};
            end else begin
               result.error    = item.src_b_reg[3] || item.src_a_reg[3] || item.dst_reg[3];
               result.halfword = thie_pkg::OP_ADD_RRR
                               | {7'd0, item.src_b_reg[2:0], item.src_a_reg[2:0],
                                  item.dst_reg[2:0]};
            end
         end
         thie_pkg::CMD_ADDRRI: begin
            result = enc_addrri(item.dst_reg, item.src_a_reg, imm_neg, imm_mag);
         end
         thie_pkg::CMD_SUBRRR: begin
            result.error    = item.src_b_reg[3] || item.src_a_reg[3] || item.dst_reg[3];
            result.halfword = thie_pkg::OP_SUB_RRR
                            | {7'd0, item.src_b_reg[2:0], item.src_a_reg[2:0],
                               item.dst_reg[2:0]};
         end
         thie_pkg::CMD_SUBRRI: begin
            result = enc_addrri(item.dst_reg, item.src_a_reg, sub_neg, imm_mag);
         end
         thie_pkg::CMD_NOP: begin
            result.halfword = thie_pkg::OP_NOP;
         end
         thie_pkg::CMD_BKPT: begin
            result.error    = imm_over_byte;
            result.halfword = thie_pkg::OP_BKPT | {8'd0, imm_bits[7:0]};
         end
         thie_pkg::CMD_BREAKPOINT: begin
            // bkpt #0 first; the bx lr halfword follows from the result stage.
            result.halfword = thie_pkg::OP_BKPT;
            result.last     = 1'b0;
         end
         default: begin
            result.error    = 1'b1;
         end
      endcase
   end

endmodule

[design/thumb_instruction_encoder_unit.sv]
`timescale 1ns / 1ps
// A command accepted into the input register is encoded combinationally and loaded into
// the result register, whose content drives rsp_. Throughput: one command per cycle while
// the response channel does not stall; the breakpoint command holds the result register for
// both its halfwords, because they leave through the single result register in turn.
// Reset (synchronous, active high) empties the input and result registers; payload is not
// cleared. The block holds no other state.

module thumb_instruction_encoder_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_command,
   input  logic [3:0]  req_dst_reg,
   input  logic [3:0]  req_src_a_reg,
   input  logic [3:0]  req_src_b_reg,
   input  logic signed [10:0] req_immediate,
   input  logic [8:0]  req_reg_list,
   input  logic [7:0]  req_fixup_distance,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_halfword,
   output logic        rsp_last,
   output logic        rsp_error
);

   // Input register: holds one request transaction until the result register can take it.
   logic                    in_valid_ff;
   logic                    in_valid_in;
   thie_pkg::req_item_type  in_item_ff;
   thie_pkg::req_item_type  in_item_in;

   // Result register: the halfword currently offered on the response channel.
   logic                    out_valid_ff;
   logic                    out_valid_in;
   thie_pkg::enc_result_type out_result_ff;
   thie_pkg::enc_result_type out_result_in;

   thie_pkg::enc_result_type enc_result;

   logic req_accept;
   logic out_take;
   logic out_second_due;
   logic out_free;
   logic in_move;

   thie_encoder u_encoder (
      .item   (in_item_ff),
      .result (enc_result)
   );

   // A response transaction completes when the consumer does not stall it. If that halfword was
   // the first of a pair, the result register reloads itself with bx lr and the input register
   // waits; otherwise the register is free to take the next encoded command in the same cycle.
   assign out_take       = out_valid_ff && !rsp_stall;
   assign out_second_due = out_take && !out_result_ff.last;
   assign out_free       = !out_valid_ff || (out_take && out_result_ff.last);
   assign in_move        = in_valid_ff && out_free;

   // The input register accepts whenever it is empty or its content moves on this cycle.
   assign req_stall  = in_valid_ff && !in_move;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_item_in.command        = thie_pkg::command_type'(req_command);
      in_item_in.dst_reg        = req_dst_reg;
      in_item_in.src_a_reg      = req_src_a_reg;
      in_item_in.src_b_reg      = req_src_b_reg;
      in_item_in.immediate      = req_immediate;
      in_item_in.reg_list       = req_reg_list;
      in_item_in.fixup_distance = req_fixup_distance;
   end

   always_comb begin
      priority if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      out_result_in = out_result_ff;
      priority if (out_second_due) begin
         out_valid_in           = 1'b1;
         out_result_in.halfword = thie_pkg::OP_BX_LR;
         out_result_in.last     = 1'b1;
         out_result_in.error    = 1'b0;
      end else if (in_move) begin
         out_valid_in  = 1'b1;
         out_result_in = enc_result;
      end else if (out_take) begin
         out_valid_in  = 1'b0;
      end else begin
         out_valid_in  = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only when their stage takes a new transaction.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (out_second_due || in_move) begin
         out_result_ff <= out_result_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_halfword = out_result_ff.halfword;
   assign rsp_last     = out_result_ff.last;
   assign rsp_error    = out_result_ff.error;

   // Once the first halfword of a pair is taken, bx lr must be offered next, error-free.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (out_take && !out_result_ff.last) |=>
         (out_valid_ff && out_result_ff.last && !out_result_ff.error
          && out_result_ff.halfword == thie_pkg::OP_BX_LR))
      else $error("second halfword of a pair not presented");

   // The input register must not hand over a command while a pair is still being sent.
   a_no_move_mid_pair: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_result_ff.last) |-> !in_move)
      else $error("command overwrote an unfinished pair");

   // A stalled input register still holds its command on the next edge.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_move) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held command lost in the input register");

   // The first halfword of a pair never carries an error.
   a_pair_head_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_result_ff.last) |-> !out_result_ff.error)
      else $error("error flagged on the first halfword of a pair");

endmodule

[tb/thie_tb_pkg.sv]
`timescale 1ns / 1ps

package thie_tb_pkg;
   import thie_pkg::*;

   // Keeps the encodings still owed by the block, in order, and checks results against them.
   class encoder_scoreboard;
      enc_result_type expected_q[$];
      int unsigned    commands_noted;
      int unsigned    halfwords_checked;
      int unsigned    flagged_errors;
      int unsigned    mismatches;

      function new();
         commands_noted    = 0;
         halfwords_checked = 0;
         flagged_errors    = 0;
         mismatches        = 0;
      endfunction

      // A 3-bit register slot only holds r0-r7.
      function logic [2:0] low_reg(logic [3:0] r, inout bit err);
         if (r > 4'd7) err = 1'b1;
         return r[2:0];
      endfunction

      function logic [15:0] mem_form(logic [3:0] t, logic [3:0] base, int off, inout bit err);
         logic [10:0] uo;
         uo = off[10:0];
         if (off < 0 || off[1:0] != 2'b00) err = 1'b1;
         if (base == REG_SP) begin
            if (off > 1020) err = 1'b1;
            return OP_MEM_SP | {5'd0, low_reg(t, err), 8'd0} | {8'd0, uo[9:2]};
         end
         if (off > 124) err = 1'b1;
         return OP_MEM_IMM | {5'd0, uo[6:2], 6'd0} | {10'd0, low_reg(base, err), 3'd0}
            | {13'd0, low_reg(t, err)};
      endfunction

      function logic [15:0] addimm_form(logic [3:0] d, int imm, inout bit err);
         int mag;
         mag = (imm < 0) ? -imm : imm;
         if (d == REG_SP) begin
            if (mag[1:0] != 2'b00 || mag > 508) err = 1'b1;
            // Bit 7 selects the SP subtract form.
            return OP_ADD_SPIMM | ((imm < 0) ? 16'h0080 : 16'h0000) | {9'd0, mag[8:2]};
         end
         if (mag > 255) err = 1'b1;
         // Bit 11 turns the 8-bit immediate add into a subtract.
         return OP_ADD_IMM8 | ((imm < 0) ? 16'h0800 : 16'h0000)
            | {5'd0, low_reg(d, err), 8'd0} | {8'd0, mag[7:0]};
      endfunction

      function logic [15:0] addrri_form(logic [3:0] d, logic [3:0] l, int imm, inout bit err);
         int mag;
         mag = (imm < 0) ? -imm : imm;
         if (l == d) return addimm_form(d, imm, err);
         if (l == REG_SP || l == REG_PC) begin
            if (imm < 0 || mag[1:0] != 2'b00 || mag > 1020) err = 1'b1;
            // Bit 11 picks SP rather than PC as the base.
            return OP_ADR | ((l == REG_SP) ? 16'h0800 : 16'h0000)
               | {5'd0, low_reg(d, err), 8'd0} | {8'd0, mag[9:2]};
         end
         if (mag > 7) err = 1'b1;
         // Bit 9 selects the 3-bit immediate subtract.
         return OP_ADD_IMM3 | ((imm < 0) ? 16'h0200 : 16'h0000) | {7'd0, mag[2:0], 6'd0}
            | {10'd0, low_reg(l, err), 3'd0} | {13'd0, low_reg(d, err)};
      endfunction

      function void note_command(req_item_type it);
         logic [15:0]    hw;
         bit             err;
         int             imm;
         enc_result_type res;
         hw  = 16'd0;
         err = 1'b0;
         imm = $signed(it.immediate);
         commands_noted++;
         case (it.command)
            CMD_BX:  hw = OP_BX | {9'd0, it.dst_reg, 3'd0};
            CMD_BLX: hw = OP_BLX | {9'd0, it.dst_reg, 3'd0};
            CMD_CBZ, CMD_CBNZ: begin
               if (it.fixup_distance > 8'd63) err = 1'b1;
               hw = ((it.command == CMD_CBZ) ? OP_CBZ : OP_CBNZ)
                  | {13'd0, low_reg(it.dst_reg, err)} | {6'd0, it.fixup_distance[5], 9'd0}
                  | {8'd0, it.fixup_distance[4:0], 3'd0};
            end
            CMD_PUSH, CMD_POP: begin
               if (it.reg_list == 9'd0) err = 1'b1;
               hw = ((it.command == CMD_PUSH) ? OP_PUSH : OP_POP) | {7'd0, it.reg_list};
            end
            CMD_LDR_LIT:
               hw = OP_LDR_LIT | {5'd0, low_reg(it.dst_reg, err), 8'd0} | {8'd0, it.fixup_distance};
            CMD_LDR: hw = mem_form(it.dst_reg, it.src_a_reg, imm, err) | OP_MEM_LOAD;
            CMD_STR: hw = mem_form(it.dst_reg, it.src_a_reg, imm, err);
            CMD_MOV: begin
               if (it.dst_reg <= 4'd7 && it.src_b_reg <= 4'd7)
                  hw = OP_MOV_LO | {10'd0, it.src_b_reg[2:0], 3'd0} | {13'd0, it.dst_reg[2:0]};
               else
                  hw = OP_MOV_HI | {8'd0, it.dst_reg[3], 7'd0} | {9'd0, it.src_b_reg, 3'd0}
                     | {13'd0, it.dst_reg[2:0]};
            end
            CMD_MOVIMM: begin
               if (imm < 0 || imm > 255) err = 1'b1;
               hw = OP_MOVIMM | {5'd0, low_reg(it.dst_reg, err), 8'd0} | {8'd0, it.immediate[7:0]};
            end
            CMD_ADDIMM: hw = addimm_form(it.dst_reg, imm, err);
            CMD_ADDRRR: begin
               if (it.src_a_reg == it.dst_reg)
                  hw = OP_ADD_HI | {8'd0, it.dst_reg[3], 7'd0} | {13'd0, it.dst_reg[2:0]}
                     | {9'd0, it.src_b_reg, 3'd0};
               else
                  hw = OP_ADD_RRR | {7'd0, low_reg(it.src_b_reg, err), 6'd0}
                     | {10'd0, low_reg(it.src_a_reg, err), 3'd0} | {13'd0, low_reg(it.dst_reg, err)};
            end
            CMD_ADDRRI: hw = addrri_form(it.dst_reg, it.src_a_reg, imm, err);
            CMD_SUBRRR:
               hw = OP_SUB_RRR | {7'd0, low_reg(it.src_b_reg, err), 6'd0}
                  | {10'd0, low_reg(it.src_a_reg, err), 3'd0} | {13'd0, low_reg(it.dst_reg, err)};
            CMD_SUBRRI: hw = addrri_form(it.dst_reg, it.src_a_reg, -imm, err);
            CMD_NOP: hw = OP_NOP;
            CMD_BKPT: begin
               if (imm < 0 || imm > 255) err = 1'b1;
               hw = OP_BKPT | {8'd0, it.immediate[7:0]};
            end
            CMD_BREAKPOINT: begin
               res.halfword = OP_BKPT;
               res.last     = 1'b0;
               res.error    = 1'b0;
               expected_q.push_back(res);
               res.halfword = OP_BX_LR;
               res.last     = 1'b1;
               expected_q.push_back(res);
               return;
            end
            default: begin
               hw  = 16'd0;
               err = 1'b1;
            end
         endcase
         res.halfword = hw;
         res.last     = 1'b1;
         res.error    = err;
         expected_q.push_back(res);
      endfunction

      function void check_halfword(logic [15:0] hw, logic last, logic err);
         enc_result_type want;
         halfwords_checked++;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: halfword %h last %b error %b", hw, last, err);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (want.error) flagged_errors++;
         if (hw !== want.halfword) begin
            $error("field halfword: expected %h, actual %h", want.halfword, hw);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("field last: expected %b, actual %b", want.last, last);
            mismatches++;
         end
         if (err !== want.error) begin
            $error("field error: expected %b, actual %b", want.error, err);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import thie_pkg::*;
   import thie_tb_pkg::*;

   // The random part is split evenly over three idling mixes.
   localparam int unsigned RANDOM_PER_PHASE = 430;
   // Drain time after the last owed halfword, so that any stray result still shows up.
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned RESET_CYCLES     = 12;
   // Command codes past the last defined one must come back as a lone error halfword.
   localparam logic [4:0]  FIRST_UNDEFINED_CMD = CMD_BREAKPOINT + 5'd1;
   localparam logic [4:0]  LAST_UNDEFINED_CMD  = 5'h1f;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic [4:0]         req_command        = '0;
   logic [3:0]         req_dst_reg        = '0;
   logic [3:0]         req_src_a_reg      = '0;
   logic [3:0]         req_src_b_reg      = '0;
   logic signed [10:0] req_immediate      = '0;
   logic [8:0]         req_reg_list       = '0;
   logic [7:0]         req_fixup_distance = '0;
   logic               rsp_stall          = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic [15:0]        rsp_halfword;
   logic               rsp_last;
   logic               rsp_error;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int unsigned        sender_idle_pct    = 0;
   int unsigned        receiver_stall_pct = 0;

   encoder_scoreboard  encoding_board;

   always #5 clock = ~clock;

   thumb_instruction_encoder_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_dst_reg        (req_dst_reg),
      .req_src_a_reg      (req_src_a_reg),
      .req_src_b_reg      (req_src_b_reg),
      .req_immediate      (req_immediate),
      .req_reg_list       (req_reg_list),
      .req_fixup_distance (req_fixup_distance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_halfword       (rsp_halfword),
      .rsp_last           (rsp_last),
      .rsp_error          (rsp_error)
   );

   // Receiver side. Values read here are those that stood before the edge, so a result
   // transaction is taken exactly when valid was high and our stall was low at this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         if (rsp_valid && !rsp_stall)
            encoding_board.check_halfword(rsp_halfword, rsp_last, rsp_error);
      end
   end

   // Presents one command, possibly after some idle cycles, and holds it until the block
   // takes it. Valid stays high on return so that back-to-back commands leave no gap.
   task automatic send_command(input command_type cmd, input logic [3:0] d,
                               input logic [3:0] l, input logic [3:0] r, input int imm,
                               input logic [8:0] list, input logic [7:0] distance);
      req_item_type it;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      it.command        = cmd;
      it.dst_reg        = d;
      it.src_a_reg      = l;
      it.src_b_reg      = r;
      it.immediate      = imm[10:0];
      it.reg_list       = list;
      it.fixup_distance = distance;
      req_valid          <= 1'b1;
      req_command        <= it.command;
      req_dst_reg        <= it.dst_reg;
      req_src_a_reg      <= it.src_a_reg;
      req_src_b_reg      <= it.src_b_reg;
      req_immediate      <= it.immediate;
      req_reg_list       <= it.reg_list;
      req_fixup_distance <= it.fixup_distance;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      encoding_board.note_command(it);
   endtask

   // Random commands, biased towards the corners that matter: low registers half the time,
   // SP and PC bases and matching source and destination for the add forms, word-aligned
   // offsets, small signed values and the occasional empty register list. A few use
   // undefined command codes.
   task automatic send_random();
      command_type cmd;
      logic [3:0]  d;
      logic [3:0]  l;
      logic [3:0]  r;
      int          imm;
      logic [8:0]  list;
      logic [7:0]  distance;
      if ($urandom_range(99) < 4)
         cmd = command_type'($urandom_range(LAST_UNDEFINED_CMD, FIRST_UNDEFINED_CMD));
      else
         cmd = command_type'($urandom_range(CMD_BREAKPOINT));
      d = ($urandom_range(1) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
      r = ($urandom_range(1) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
      case ($urandom_range(7))
         0:       l = d;
         1:       l = REG_SP;
         2:       l = REG_PC;
         default: l = ($urandom_range(1) != 0) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
      endcase
      case ($urandom_range(3))
         0:       imm = int'($urandom_range(2047)) - 1024;
         1:       imm = int'($urandom_range(255)) * 4;
         2:       imm = int'($urandom_range(16)) - 8;
         default: imm = int'($urandom_range(510)) - 255;
      endcase
      list = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(511));
      distance = ($urandom_range(1) != 0) ? 8'($urandom_range(63)) : 8'($urandom_range(255));
      send_command(cmd, d, l, r, imm, list, distance);
   endtask

   // Holds the sender back until every owed halfword has been seen, then a few cycles more.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (encoding_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      encoding_board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions under the first idling mix: field extremes, every command,
      // high registers in low slots, empty lists, misaligned and out-of-range offsets, the
      // subtract forms, the same-register add forms and an undefined command code.
      sender_idle_pct    = 17;
      receiver_stall_pct <= 83;
      send_command(CMD_BX,         REG_LR, 4'd0,   4'd0,  0,     9'd0,   8'd0);
      send_command(CMD_BLX,        REG_PC, 4'd0,   4'd0,  0,     9'd0,   8'd0);
      send_command(CMD_CBZ,        4'd0,   4'd0,   4'd0,  0,     9'd0,   8'd63);
      send_command(CMD_CBNZ,       4'd9,   4'd0,   4'd0,  0,     9'd0,   8'd255);
      send_command(CMD_PUSH,       4'd0,   4'd0,   4'd0,  0,     9'h1ff, 8'd0);
      send_command(CMD_POP,        4'd0,   4'd0,   4'd0,  0,     9'd0,   8'd0);
      send_command(CMD_LDR_LIT,    4'd7,   4'd0,   4'd0,  0,     9'd0,   8'd255);
      send_command(CMD_LDR,        4'd1,   REG_SP, 4'd0,  1020,  9'd0,   8'd0);
      send_command(CMD_STR,        4'd2,   4'd3,   4'd0,  124,   9'd0,   8'd0);
      send_command(CMD_LDR,        4'd3,   4'd4,   4'd0,  126,   9'd0,   8'd0);
      send_command(CMD_STR,        4'd0,   REG_SP, 4'd0,  -4,    9'd0,   8'd0);
      send_command(CMD_MOV,        REG_PC, 4'd0,   4'd3,  0,     9'd0,   8'd0);
      send_command(CMD_MOVIMM,     4'd0,   4'd0,   4'd0,  255,   9'd0,   8'd0);
      send_command(CMD_MOVIMM,     4'd8,   4'd0,   4'd0,  -1,    9'd0,   8'd0);
      send_command(CMD_ADDIMM,     REG_SP, 4'd0,   4'd0,  -508,  9'd0,   8'd0);
      send_command(CMD_ADDIMM,     4'd5,   4'd0,   4'd0,  -1024, 9'd0,   8'd0);
      send_command(CMD_ADDRRR,     4'd4,   4'd4,   4'd12, 0,     9'd0,   8'd0);
      send_command(CMD_ADDRRI,     4'd3,   REG_SP, 4'd0,  1020,  9'd0,   8'd0);
      send_command(CMD_ADDRRI,     4'd6,   4'd2,   4'd0,  -7,    9'd0,   8'd0);
      send_command(CMD_SUBRRI,     4'd1,   REG_PC, 4'd0,  -4,    9'd0,   8'd0);
      send_command(CMD_SUBRRR,     4'd7,   4'd15,  4'd0,  0,     9'd0,   8'd0);
      send_command(CMD_NOP,        4'd15,  4'd15,  4'd15, 1023,  9'h1ff, 8'd255);
      send_command(CMD_BKPT,       4'd0,   4'd0,   4'd0,  1023,  9'd0,   8'd0);
      send_command(CMD_BREAKPOINT, 4'd0,   4'd0,   4'd0,  0,     9'd0,   8'd0);
      send_command(command_type'(LAST_UNDEFINED_CMD), 4'd0, 4'd0, 4'd0, 0, 9'd0, 8'd0);
      drain_results();

      // Sender mostly present, receiver mostly stalling: the output register backs up.
      repeat (RANDOM_PER_PHASE) send_random();
      drain_results();

      // Sender mostly idle, receiver mostly ready.
      sender_idle_pct    = 83;
      receiver_stall_pct <= 17;
      repeat (RANDOM_PER_PHASE) send_random();
      drain_results();

      // Full rate in both directions.
      sender_idle_pct    = 0;
      receiver_stall_pct <= 0;
      repeat (RANDOM_PER_PHASE) send_random();
      drain_results();

      $display("Covered %0d command transactions (directed corners plus three idling mixes).",
               encoding_board.commands_noted);
      $display("Checked %0d result transactions, %0d of them carrying the error flag.",
               encoding_board.halfwords_checked, encoding_board.flagged_errors);
      if (encoding_board.mismatches == 0)
         $display("thumb_instruction_encoder_unit verification clean");
      else
         $display("thumb_instruction_encoder_unit verification failed");
      $finish;
   end

   // Watchdog: far longer than the slowest legal run needs.
   initial begin
      #2000000;
      $display("thumb_instruction_encoder_unit verification failed");
      $finish;
   end

endmodule

[filelist.f]
design/thie_pkg.sv
design/thie_encoder.sv
design/thumb_instruction_encoder_unit.sv
tb/thie_tb_pkg.sv
tb/tb.sv
